// File: rtl/leq_pkg.sv
// Package for the lossy event queue: sizes, field types, codes and the
// command and status structures between controller and datapath.
// Depends on nothing; every other file of the block uses it.
package leq_pkg;

   // Storage sizes.
   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int MAX_RESULTS  = 16;

   // Fixed field widths of the channels and the register.
   localparam int KIND_BITS   = 3;
   localparam int STATUS_BITS = 8;
   localparam int TAG_BITS    = 32;
   localparam int COUNT_BITS  = 5;
   localparam int LIMIT_BITS  = 5;
   localparam int DROP_BITS   = 32;

   // Derived widths.
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CMP_BITS    = (FILL_BITS > LIMIT_BITS) ? FILL_BITS : LIMIT_BITS;
   localparam int REMAIN_BITS = $clog2(MAX_RESULTS + 1);

   typedef logic [KIND_BITS-1:0]    kind_type;
   typedef logic [STATUS_BITS-1:0]  status_type;
   typedef logic [TAG_BITS-1:0]     tag_type;
   typedef logic [PAYLOAD_BITS-1:0] stored_payload_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [LIMIT_BITS-1:0]   limit_type;
   typedef logic [DROP_BITS-1:0]    drop_type;
   typedef logic [FILL_BITS-1:0]    fill_type;
   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [CMP_BITS-1:0]     cmp_type;
   typedef logic [REMAIN_BITS-1:0]  remain_type;

   // Codes.
   localparam logic     OP_PUSH     = 1'b0;
   localparam logic     OP_POLL     = 1'b1;
   localparam kind_type KIND_FRAME  = 3'd0;
   localparam limit_type LIMIT_RESET = 5'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // register the push fields of an accepted request
      logic push;     // apply the registered push to the queue
      logic load;     // load the output register
      logic pop;      // with load: take the head entry, otherwise an empty result
      logic last;     // with load: mark the result as the final one of the poll
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      fill_type fill;
      logic     out_free;
   } dp_status_type;

   // Reduce a request payload to its stored width.
   function automatic stored_payload_type pack_payload(input tag_type tag);
      logic [PAYLOAD_BITS+TAG_BITS-1:0] wide;
      wide = {{PAYLOAD_BITS{1'b0}}, tag};
      return wide[PAYLOAD_BITS-1:0];
   endfunction

   // Bring a stored payload back to the result width.
   function automatic tag_type unpack_payload(input stored_payload_type payload);
      logic [PAYLOAD_BITS+TAG_BITS-1:0] wide;
      wide = {{TAG_BITS{1'b0}}, payload};
      return wide[TAG_BITS-1:0];
   endfunction

endpackage

// File: rtl/leq_req_if.sv
// Request channel of the lossy event queue: valid/ready handshake and the
// push or poll fields. Depends on leq_pkg.
interface leq_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   leq_pkg::kind_type    event_kind;
   leq_pkg::status_type  status_code;
   leq_pkg::tag_type     payload_tag;
   leq_pkg::count_type   poll_count;

   modport source (output valid, op, event_kind, status_code, payload_tag, poll_count,
                   input ready);
   modport sink   (input valid, op, event_kind, status_code, payload_tag, poll_count,
                   output ready);
endinterface

// File: rtl/leq_rsp_if.sv
// Response channel of the lossy event queue: valid/ready handshake and the
// dequeued event fields. Depends on leq_pkg.
interface leq_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 present;
   leq_pkg::kind_type    kind_out;
   leq_pkg::status_type  status_out;
   leq_pkg::tag_type     payload_out;
   logic                 last;
   leq_pkg::drop_type    drop_total;

   modport source (output valid, present, kind_out, status_out, payload_out, last,
                   drop_total, input ready);
   modport sink   (input valid, present, kind_out, status_out, payload_out, last,
                   drop_total, output ready);
endinterface

// File: rtl/lossy_event_queue_frame_first_drop.sv
// Top level of the lossy event queue: joins the controller and datapath to
// the request, response and register ports. Depends on leq_pkg, the
// channel interfaces, leq_controller and leq_datapath.
//
// A bounded event queue whose fill limit is set by csr_wr_data (reset 16,
// capped at the queue depth). A push is accepted, and in the following
// cycle the entry array is updated in one step, which drops a data frame
// at the limit (any push at a zero limit) or lets a status event evict
// the oldest data frame (or the head) and then appends it. A poll is
// accepted, then each result leaves through a single output register
// while the entry array shifts by one; a stall on the response side holds
// back the next result. An empty or zero poll returns one result with
// present low. A new request is taken while the last result of a poll
// still waits in the output register. Write the limit only while the
// block is idle.
module lossy_event_queue_frame_first_drop (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  leq_pkg::limit_type csr_wr_data,
   leq_req_if.sink            req_bus,
   leq_rsp_if.source          rsp_bus
);

   leq_pkg::dp_cmd_type    cmd;
   leq_pkg::dp_status_type status;

   // Sequencing of requests.
   leq_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_op         (req_bus.op),
      .req_poll_count (req_bus.poll_count),
      .status         (status),
      .cmd            (cmd)
   );

   // Queue storage, counters and output register.
   leq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_kind    (req_bus.event_kind),
      .req_status  (req_bus.status_code),
      .req_tag     (req_bus.payload_tag),
      .cmd         (cmd),
      .status      (status),
      .rsp_bus     (rsp_bus)
   );

endmodule

// File: rtl/leq_datapath.sv
// Datapath of the lossy event queue: compacting entry array, fill level,
// drop counter, limit register and the response output register.
// Depends on leq_pkg and leq_rsp_if.
module leq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  leq_pkg::limit_type      csr_wr_data,
   input  leq_pkg::kind_type       req_kind,
   input  leq_pkg::status_type     req_status,
   input  leq_pkg::tag_type        req_tag,
   input  leq_pkg::dp_cmd_type     cmd,
   output leq_pkg::dp_status_type  status,
   leq_rsp_if.source               rsp_bus
);

   // Registers.
   leq_pkg::limit_type          limit_ff, limit_in;
   leq_pkg::fill_type           fill_ff, fill_in;
   leq_pkg::drop_type           drop_ff, drop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   leq_pkg::kind_type           new_kind_ff;
   leq_pkg::status_type         new_status_ff;
   leq_pkg::stored_payload_type new_payload_ff;
   leq_pkg::kind_type           ent_kind_ff    [leq_pkg::QUEUE_DEPTH];
   leq_pkg::kind_type           ent_kind_in    [leq_pkg::QUEUE_DEPTH];
   leq_pkg::status_type         ent_status_ff  [leq_pkg::QUEUE_DEPTH];
   leq_pkg::status_type         ent_status_in  [leq_pkg::QUEUE_DEPTH];
   leq_pkg::stored_payload_type ent_payload_ff [leq_pkg::QUEUE_DEPTH];
   leq_pkg::stored_payload_type ent_payload_in [leq_pkg::QUEUE_DEPTH];
   logic                        out_present_ff;
   leq_pkg::kind_type           out_kind_ff;
   leq_pkg::status_type         out_status_ff;
   leq_pkg::tag_type            out_payload_ff;
   logic                        out_last_ff;
   leq_pkg::drop_type           out_drop_ff;

   // Combinational helpers.
   leq_pkg::cmp_type  limit_cmp;
   leq_pkg::cmp_type  eff_limit;
   logic              limit_zero;
   logic              queue_full;
   logic              is_frame;
   logic              count_drop;
   logic              do_append;
   logic              do_evict;
   leq_pkg::fill_type fill_dec;
   leq_pkg::idx_type  victim;

   // Effective limit: the register, capped at the queue depth.
   always_comb begin
      limit_cmp  = leq_pkg::CMP_BITS'(limit_ff);
      eff_limit  = (limit_cmp > leq_pkg::CMP_BITS'(leq_pkg::QUEUE_DEPTH)) ?
                   leq_pkg::CMP_BITS'(leq_pkg::QUEUE_DEPTH) : limit_cmp;
      limit_zero = (eff_limit == '0);
      queue_full = (leq_pkg::CMP_BITS'(fill_ff) >= eff_limit);
      is_frame   = (new_kind_ff == leq_pkg::KIND_FRAME);
      fill_dec   = fill_ff - 1'b1;
   end

   // Push decision: drop, evict and append, or plain append.
   always_comb begin
      count_drop = cmd.push && (limit_zero || queue_full);
      do_evict   = cmd.push && !limit_zero && queue_full && !is_frame;
      do_append  = cmd.push && !limit_zero && !queue_full;
   end

   // Eviction victim: the oldest data frame, or the head when none is queued.
   always_comb begin
      victim = '0;
      for (int i = leq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if ((leq_pkg::FILL_BITS'(i) < fill_ff) && (ent_kind_ff[i] == leq_pkg::KIND_FRAME)) begin
            victim = leq_pkg::IDX_BITS'(i);
         end
      end
   end

   // Entry array next values: shift on pop, close the gap and append on eviction, append on a plain push.
   always_comb begin
      int nxt;
      for (int i = 0; i < leq_pkg::QUEUE_DEPTH; i++) begin
         nxt = (i < leq_pkg::QUEUE_DEPTH - 1) ? i + 1 : i;
         ent_kind_in[i]    = ent_kind_ff[i];
         ent_status_in[i]  = ent_status_ff[i];
         ent_payload_in[i] = ent_payload_ff[i];
         priority if (cmd.load && cmd.pop) begin
            ent_kind_in[i]    = ent_kind_ff[nxt];
            ent_status_in[i]  = ent_status_ff[nxt];
            ent_payload_in[i] = ent_payload_ff[nxt];
         end else if (do_evict && (leq_pkg::FILL_BITS'(i) == fill_dec)) begin
            ent_kind_in[i]    = new_kind_ff;
            ent_status_in[i]  = new_status_ff;
            ent_payload_in[i] = new_payload_ff;
         end else if (do_evict && (leq_pkg::FILL_BITS'(i) < fill_dec) &&
                      (leq_pkg::FILL_BITS'(i) >= leq_pkg::FILL_BITS'(victim))) begin
            ent_kind_in[i]    = ent_kind_ff[nxt];
            ent_status_in[i]  = ent_status_ff[nxt];
            ent_payload_in[i] = ent_payload_ff[nxt];
         end else if (do_append && (leq_pkg::FILL_BITS'(i) == fill_ff)) begin
            ent_kind_in[i]    = new_kind_ff;
            ent_status_in[i]  = new_status_ff;
            ent_payload_in[i] = new_payload_ff;
         end else begin
            ent_kind_in[i]    = ent_kind_ff[i];
         end
      end
   end

   // Control state next values: limit, fill level, drop counter, output valid.
   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;

      fill_in = fill_ff;
      if (cmd.load && cmd.pop) begin
         fill_in = fill_dec;
      end else if (do_append) begin
         fill_in = fill_ff + 1'b1;
      end

      drop_in = drop_ff;
      if (count_drop && (drop_ff != '1)) begin
         drop_in = drop_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= leq_pkg::LIMIT_RESET;
         fill_ff      <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Entry array and captured push fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_kind_ff    <= req_kind;
         new_status_ff  <= req_status;
         new_payload_ff <= leq_pkg::pack_payload(req_tag);
      end
      for (int i = 0; i < leq_pkg::QUEUE_DEPTH; i++) begin
         ent_kind_ff[i]    <= ent_kind_in[i];
         ent_status_ff[i]  <= ent_status_in[i];
         ent_payload_ff[i] <= ent_payload_in[i];
      end
   end

   // Output register: head entry or an empty result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_present_ff <= cmd.pop;
         out_kind_ff    <= cmd.pop ? ent_kind_ff[0] : '0;
         out_status_ff  <= cmd.pop ? ent_status_ff[0] : '0;
         out_payload_ff <= cmd.pop ? leq_pkg::unpack_payload(ent_payload_ff[0]) : '0;
         out_last_ff    <= cmd.last;
         out_drop_ff    <= drop_ff;
      end
   end

   // Ports.
   assign status.fill        = fill_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.present    = out_present_ff;
   assign rsp_bus.kind_out   = out_kind_ff;
   assign rsp_bus.status_out = out_status_ff;
   assign rsp_bus.payload_out = out_payload_ff;
   assign rsp_bus.last       = out_last_ff;
   assign rsp_bus.drop_total = out_drop_ff;

`ifndef SYNTHESIS
   // The fill level never goes beyond the storage.
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= leq_pkg::FILL_BITS'(leq_pkg::QUEUE_DEPTH))
      else $error("fill level beyond queue depth");

   // The drop counter only ever grows or holds.
   a_drop_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> drop_ff >= $past(drop_ff))
      else $error("drop counter decreased");

   // A head entry is only taken from a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.pop) |-> fill_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

// File: rtl/leq_controller.sv
// Controller of the lossy event queue: accepts requests, sequences a push
// update or the results of a poll. Depends on leq_pkg.
module leq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  leq_pkg::count_type      req_poll_count,
   input  leq_pkg::dp_status_type  status,
   output leq_pkg::dp_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_POLL = 2'd2;

   logic [1:0]          state_ff, state_in;
   leq_pkg::remain_type remain_ff, remain_in;
   leq_pkg::cmp_type    want_cmp;
   leq_pkg::cmp_type    fill_cmp;
   leq_pkg::cmp_type    count_cmp;

   // Number of results of a poll: the request, capped by fill and result limit.
   always_comb begin
      want_cmp  = leq_pkg::CMP_BITS'(req_poll_count);
      fill_cmp  = leq_pkg::CMP_BITS'(status.fill);
      count_cmp = (want_cmp < fill_cmp) ? want_cmp : fill_cmp;
      if (count_cmp > leq_pkg::CMP_BITS'(leq_pkg::MAX_RESULTS)) begin
         count_cmp = leq_pkg::CMP_BITS'(leq_pkg::MAX_RESULTS);
      end
   end

   // State transitions and commands.
   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == leq_pkg::OP_PUSH) begin
                  state_in = ST_PUSH;
               end else begin
                  remain_in = leq_pkg::REMAIN_BITS'(count_cmp);
                  state_in  = ST_POLL;
               end
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_POLL: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (remain_ff == '0) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop   = 1'b1;
                  cmd.last  = (remain_ff == leq_pkg::REMAIN_BITS'(1));
                  remain_in = remain_ff - 1'b1;
                  if (remain_ff == leq_pkg::REMAIN_BITS'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

`ifndef SYNTHESIS
   // Entries still owed to a poll imply a non-empty queue.
   a_remain_has_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POLL && remain_ff != '0) |-> status.fill != '0)
      else $error("poll owes entries but queue is empty");

   // The output register is only loaded when it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("output register overwritten");

   // The final result of a poll returns the controller to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last) |=> state_ff == ST_IDLE)
      else $error("controller not idle after final result");
`endif

endmodule

// File: sim/tb.sv
// Testbench for lossy_event_queue_frame_first_drop: directed and random push and poll
// requests, checked against a predictor of the queue kept in this file.
// Depends on leq_pkg, leq_req_if, leq_rsp_if and the block's top level.
module tb;

   // One queued event as the block holds it.
   typedef struct packed {
      leq_pkg::kind_type           kind;
      leq_pkg::status_type         status;
      leq_pkg::stored_payload_type payload;
   } event_entry_type;

   // One result of a poll as it leaves the block.
   typedef struct packed {
      logic                present;
      leq_pkg::kind_type   kind;
      leq_pkg::status_type status;
      leq_pkg::tag_type    payload;
      logic                last;
      leq_pkg::drop_type   drops;
   } poll_result_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   leq_pkg::limit_type csr_wr_data;

   leq_req_if req_bus ();
   leq_rsp_if rsp_bus ();

   lossy_event_queue_frame_first_drop uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // Predicted contents of the queue, oldest first, and results still to come.
   event_entry_type    queued_events[$];
   poll_result_type    awaited_results[$];
   leq_pkg::limit_type fill_limit = leq_pkg::LIMIT_RESET;
   leq_pkg::drop_type  drop_count = '0;

   int mismatches    = 0;
   int req_gap_max   = 6;
   int rsp_stall_max = 6;
   int hold_request  = 0;
   bit rsp_hold      = 1'b0;

   // Clock with a period of two time units.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Guard against a hung run.
   initial begin
      #400000;
      $display("** lossy_event_queue_frame_first_drop: FAILED **");
      $finish;
   end

   // Saturating count of dropped or evicted events.
   function automatic void count_drop();
      if (drop_count != '1) drop_count = drop_count + 1'b1;
   endfunction

   // Apply an accepted push to the predicted queue.
   function automatic void predict_push(input leq_pkg::kind_type kind,
                                        input leq_pkg::status_type status,
                                        input leq_pkg::tag_type tag);
      int              limit;
      int              victim;
      bit              found;
      event_entry_type entry;
      limit = (fill_limit > leq_pkg::QUEUE_DEPTH) ? leq_pkg::QUEUE_DEPTH : int'(fill_limit);
      if (limit == 0) begin
         count_drop();
         return;
      end
      // At the limit a frame is lost, while a status event makes room for itself.
      if (queued_events.size() >= limit) begin
         if (kind == leq_pkg::KIND_FRAME) begin
            count_drop();
            return;
         end
         victim = 0;
         found  = 1'b0;
         foreach (queued_events[i]) begin
            if (!found && queued_events[i].kind == leq_pkg::KIND_FRAME) begin
               victim = i;
               found  = 1'b1;
            end
         end
         queued_events.delete(victim);
         count_drop();
      end
      if (queued_events.size() < leq_pkg::QUEUE_DEPTH) begin
         entry.kind    = kind;
         entry.status  = status;
         entry.payload = leq_pkg::stored_payload_type'(tag);
         queued_events = {queued_events, entry};
      end
   endfunction

   // Work out the results of an accepted poll and take the entries off the queue.
   function automatic void predict_poll(input leq_pkg::count_type want);
      int              n;
      event_entry_type head;
      poll_result_type res;
      n = want;
      if (n > queued_events.size()) n = queued_events.size();
      if (n > leq_pkg::MAX_RESULTS) n = leq_pkg::MAX_RESULTS;
      if (n == 0) begin
         res       = '0;
         res.last  = 1'b1;
         res.drops = drop_count;
         awaited_results = {awaited_results, res};
      end else begin
         for (int k = 0; k < n; k++) begin
            head = queued_events[0];
            queued_events.delete(0);
            res.present = 1'b1;
            res.kind    = head.kind;
            res.status  = head.status;
            res.payload = leq_pkg::tag_type'(head.payload);
            res.last    = (k == n - 1);
            res.drops   = drop_count;
            awaited_results = {awaited_results, res};
         end
      end
   endfunction

   // Offer one request after a random gap and predict it once it is accepted.
   task automatic send_item(input logic op, input leq_pkg::kind_type kind,
                            input leq_pkg::status_type status,
                            input leq_pkg::tag_type tag, input leq_pkg::count_type count);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.event_kind  <= kind;
      req_bus.status_code <= status;
      req_bus.payload_tag <= tag;
      req_bus.poll_count  <= count;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (op == leq_pkg::OP_PUSH) predict_push(kind, status, tag);
      else predict_poll(count);
   endtask

   // A push carries a random, unused count; a poll carries random, unused event fields.
   task automatic send_push(input leq_pkg::kind_type kind, input leq_pkg::status_type status,
                            input leq_pkg::tag_type tag);
      send_item(leq_pkg::OP_PUSH, kind, status, tag,
                leq_pkg::count_type'($urandom_range(0, 31)));
   endtask

   task automatic send_poll(input leq_pkg::count_type count);
      send_item(leq_pkg::OP_POLL, leq_pkg::kind_type'($urandom_range(0, 7)),
                leq_pkg::status_type'($urandom_range(0, 255)),
                leq_pkg::tag_type'($urandom), count);
   endtask

   // Stop offering requests and wait until every predicted result has arrived,
   // then give a trailing push time to settle.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the fill limit while the block is idle.
   task automatic write_limit(input leq_pkg::limit_type value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      fill_limit = value;
   endtask

   // Polls on an empty queue, with a zero and a non-zero count.
   task automatic test_empty_polls();
      send_poll(5'd0);
      send_poll(5'd5);
   endtask

   // Extreme field values out and back, with the largest count the field holds.
   task automatic test_field_extremes();
      send_push(3'd0, 8'h00, 32'h0000_0000);
      send_push(3'd7, 8'hFF, 32'hFFFF_FFFF);
      send_push(3'd5, 8'hA5, 32'h5A5A_A5A5);
      send_push(3'd0, 8'h5A, 32'hA5A5_5A5A);
      send_poll(5'd31);
   endtask

   // With a small limit a frame is dropped when full and a status event evicts
   // the oldest frame; also a zero poll on a queue that holds entries.
   task automatic test_frame_drop_and_eviction();
      write_limit(5'd3);
      send_push(leq_pkg::KIND_FRAME, 8'h11, 32'h0000_0A01);
      send_push(3'd2, 8'h12, 32'h0000_0A02);
      send_push(leq_pkg::KIND_FRAME, 8'h13, 32'h0000_0A03);
      send_push(leq_pkg::KIND_FRAME, 8'h14, 32'h0000_0A04);
      send_push(3'd6, 8'h15, 32'h0000_0A05);
      send_poll(5'd2);
      send_poll(5'd0);
      send_poll(5'd16);
   endtask

   // With no frame queued, a status event at the limit evicts the head.
   task automatic test_status_evicts_head();
      write_limit(5'd2);
      send_push(3'd1, 8'h21, 32'h0000_0B01);
      send_push(3'd3, 8'h22, 32'h0000_0B02);
      send_push(3'd4, 8'h23, 32'h0000_0B03);
      send_poll(5'd16);
   endtask

   // A zero limit drops every push.
   task automatic test_zero_limit();
      write_limit(5'd0);
      send_push(leq_pkg::KIND_FRAME, 8'h31, 32'h0000_0C01);
      send_push(3'd7, 8'h32, 32'h0000_0C02);
      send_poll(5'd4);
   endtask

   // Lowering the limit below the fill keeps the entries and treats the queue as full.
   task automatic test_lowered_limit();
      write_limit(5'd16);
      send_push(leq_pkg::KIND_FRAME, 8'h41, 32'h0000_0D01);
      send_push(3'd5, 8'h42, 32'h0000_0D02);
      send_push(leq_pkg::KIND_FRAME, 8'h43, 32'h0000_0D03);
      write_limit(5'd1);
      send_push(leq_pkg::KIND_FRAME, 8'h44, 32'h0000_0D04);
      send_push(3'd2, 8'h45, 32'h0000_0D05);
      send_poll(5'd16);
   endtask

   // The receiver holds off for a long stretch while requests come, so the queue fills
   // and a stalled poll blocks new requests; afterwards the sender waits for all results.
   task automatic test_backpressure();
      write_limit(5'd16);
      @(negedge clock);
      hold_request = 240;
      repeat (18) begin
         send_push(($urandom_range(0, 1) != 0) ? leq_pkg::KIND_FRAME
                                               : leq_pkg::kind_type'($urandom_range(1, 7)),
                   leq_pkg::status_type'($urandom_range(0, 255)),
                   leq_pkg::tag_type'($urandom));
      end
      send_poll(5'd16);
      send_poll(5'd4);
      send_push(3'd3, leq_pkg::status_type'($urandom_range(0, 255)),
                leq_pkg::tag_type'($urandom));
      send_poll(5'd8);
      wait_drained();
   endtask

   // Random requests in phases; each phase writes a limit and sets the idling pattern.
   task automatic test_random_traffic();
      leq_pkg::limit_type limits[8];
      int                 pick;
      limits = '{5'd31, 5'd1, 5'd16, 5'd4, 5'd0, 5'd17, 5'd2, 5'd9};
      limits[7] = leq_pkg::limit_type'($urandom_range(1, 15));
      for (int phase = 0; phase < 8; phase++) begin
         write_limit(limits[phase]);
         // Some phases run with no idling on one side or on both.
         req_gap_max   = (phase == 2 || phase == 5) ? 0 : 6;
         rsp_stall_max = (phase == 2 || phase == 6) ? 0 : 6;
         repeat (28) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
               send_push(($urandom_range(0, 1) != 0) ? leq_pkg::KIND_FRAME
                                 : leq_pkg::kind_type'($urandom_range(1, 7)),
                         leq_pkg::status_type'($urandom_range(0, 255)),
                         leq_pkg::tag_type'($urandom));
            end else if (pick < 68) begin
               send_poll(5'd0);
            end else if (pick < 90) begin
               send_poll(leq_pkg::count_type'($urandom_range(1, 6)));
            end else if (pick < 97) begin
               send_poll(leq_pkg::count_type'($urandom_range(7, 16)));
            end else begin
               send_poll(leq_pkg::count_type'($urandom_range(17, 31)));
            end
         end
      end
      req_gap_max   = 6;
      rsp_stall_max = 6;
   endtask

   // Receiver: a random stall before each result, and the long hold-off on request.
   initial begin : receiver
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         while (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 && !rsp_hold);
      end
   end

   // Counts out the long hold-off in clock cycles.
   initial begin : hold_counter
      forever begin
         wait (hold_request != 0);
         rsp_hold = 1'b1;
         repeat (hold_request) @(posedge clock);
         rsp_hold     = 1'b0;
         hold_request = 0;
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_check
      poll_result_type seen;
      poll_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.present = rsp_bus.present;
         seen.kind    = rsp_bus.kind_out;
         seen.status  = rsp_bus.status_out;
         seen.payload = rsp_bus.payload_out;
         seen.last    = rsp_bus.last;
         seen.drops   = rsp_bus.drop_total;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: present=%0d kind=%0d status=%h payload=%h %s%0d %s%0d",
                        seen.present, seen.kind, seen.status, seen.payload,
                        "last=", seen.last, "drops=", seen.drops);
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            if (seen.present !== want.present || seen.kind !== want.kind ||
                seen.status !== want.status || seen.payload !== want.payload ||
                seen.last !== want.last || seen.drops !== want.drops) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: expected present=%0d kind=%0d status=%h %s%h",
                           $time, want.present, want.kind, want.status,
                           "payload=", want.payload);
                  $display("                 expected last=%0d drops=%0d",
                           want.last, want.drops);
                  $display("                 actual   present=%0d kind=%0d status=%h %s%h",
                           seen.present, seen.kind, seen.status,
                           "payload=", seen.payload);
                  $display("                 actual   last=%0d drops=%0d",
                           seen.last, seen.drops);
               end
            end
         end
      end
   end

   // Reset, the tests in turn, then the verdict.
   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= leq_pkg::OP_PUSH;
      req_bus.event_kind  <= leq_pkg::KIND_FRAME;
      req_bus.status_code <= '0;
      req_bus.payload_tag <= '0;
      req_bus.poll_count  <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_polls();
      test_field_extremes();
      test_frame_drop_and_eviction();
      test_status_evicts_head();
      test_zero_limit();
      test_lowered_limit();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("** lossy_event_queue_frame_first_drop: PASSED **");
      end else begin
         $display("** lossy_event_queue_frame_first_drop: FAILED **");
      end
      $finish;
   end

endmodule
